// File: rtl/htk_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes of the HTTP request head tokenizer.
package htk_pkg;

    // Most results that one request byte can cause.
    localparam int MAX_RES = 3;

    // Default number of result groups held between the front and the back end.
    localparam int QUEUE_DEPTH = 4;

    // Token kinds.
    localparam logic [2:0] KIND_METHOD  = 3'd0;
    localparam logic [2:0] KIND_TARGET  = 3'd1;
    localparam logic [2:0] KIND_VERSION = 3'd2;
    localparam logic [2:0] KIND_NAME    = 3'd3;
    localparam logic [2:0] KIND_VALUE   = 3'd4;

    // Status codes on the marker that finishes a head.
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_SHORT_LINE = 2'd1;
    localparam logic [1:0] ST_NO_SEP     = 2'd2;

    // One result beat, without its last flag.
    typedef struct packed {
        logic [7:0] out_byte;
        logic [2:0] kind;
        logic       is_data;
        logic       token_end;
        logic       header_kept;
        logic       head_done;
        logic [1:0] status;
    } t_result;

    // All results of one request byte, in order from index zero.
    typedef struct packed {
        logic [1:0]                count;
        t_result [MAX_RES-1:0]     res;
    } t_bundle;

endpackage

// File: rtl/htk_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for request bytes and result beats.
interface htk_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface htk_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic [2:0] kind;
    logic       is_data;
    logic       token_end;
    logic       header_kept;
    logic       head_done;
    logic [1:0] status;
    logic       last;

    modport source (output valid, output out_byte, output kind, output is_data,
                    output token_end, output header_kept, output head_done,
                    output status, output last, input ready);
    modport sink   (input valid, input out_byte, input kind, input is_data,
                    input token_end, input header_kept, input head_done,
                    input status, input last, output ready);
endinterface

// File: rtl/http_request_head_tokenizer_top.sv
`timescale 1ns / 1ps
// Top level of the HTTP request head tokenizer.
//
// Input channel i_in carries one request byte per beat (in_byte). Output
// channel o_out carries tagged result beats: token bytes with their kind,
// end markers, and the marker that finishes a request head. Each input byte
// causes zero to three result beats; last is set on the final beat of a byte.
// Both channels use valid/ready and move a beat when both are high.
//
// Results of an accepted byte are registered in the result queue and
// offered from there. The front end takes one byte every cycle while the
// result queue has room; the back end sends one result beat per cycle
// while the receiver is ready. A byte with two or three results holds the
// output longer; the queue of QUEUE_DEPTH groups absorbs such bursts.
//
// Synchronous active-low reset returns the parser to the start of a request
// and empties the queue. When the receiver stalls, the current beat holds and
// input bytes keep being accepted until the queue fills, then ready drops.
module http_request_head_tokenizer_top #(
    parameter int QUEUE_DEPTH = htk_pkg::QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    htk_byte_if.sink   i_in,
    htk_res_if.source  o_out
);

    htk_pkg::t_bundle push_bundle;
    htk_pkg::t_bundle head_bundle;
    logic             push;
    logic             full;
    logic             pop;
    logic             empty;

    htk_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .o_bundle (push_bundle),
        .o_push   (push),
        .i_full   (full)
    );

    htk_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_bundle (push_bundle),
        .o_full   (full),
        .i_pop    (pop),
        .o_bundle (head_bundle),
        .o_empty  (empty)
    );

    htk_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_bundle (head_bundle),
        .i_empty  (empty),
        .o_pop    (pop),
        .o_out    (o_out)
    );

endmodule

// File: rtl/htk_front.sv
`timescale 1ns / 1ps
// Front end: accepts request bytes, tracks the parse state and builds result groups.
module htk_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    htk_byte_if.sink         i_in,
    output htk_pkg::t_bundle o_bundle,
    output logic             o_push,
    input  logic             i_full
);

    // Parse phases.
    localparam logic [2:0] PH_LINE    = 3'd0;
    localparam logic [2:0] PH_METHOD  = 3'd1;
    localparam logic [2:0] PH_TARGET  = 3'd2;
    localparam logic [2:0] PH_VERSION = 3'd3;
    localparam logic [2:0] PH_NAME    = 3'd4;
    localparam logic [2:0] PH_VALUE   = 3'd5;

    // Characters of interest.
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_COLON   = 8'h3A;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_LF      = 8'h0A;
    localparam logic [7:0] CH_DIG0    = 8'h30;
    localparam logic [7:0] CH_DIG9    = 8'h39;
    localparam logic [7:0] CH_LOW_A   = 8'h61;
    localparam logic [7:0] CH_LOW_F   = 8'h66;
    localparam logic [7:0] CH_UP_A    = 8'h41;
    localparam logic [7:0] CH_UP_F    = 8'h46;

    typedef struct packed {
        logic [2:0] phase;
        logic [1:0] held_count;
        logic [7:0] held_digit;
        logic       colon_held;
        logic       cr_held;
        logic       name_seen;
        logic       value_seen;
    } t_tok_state;

    t_tok_state       r_state;
    t_tok_state       step_state;
    htk_pkg::t_bundle step_bundle;
    logic             accept;

    function automatic logic f_is_hex(input logic [7:0] c);
        return (c >= CH_DIG0 && c <= CH_DIG9) || (c >= CH_LOW_A && c <= CH_LOW_F) ||
               (c >= CH_UP_A && c <= CH_UP_F);
    endfunction

    function automatic logic [3:0] f_hex_val(input logic [7:0] c);
        logic [7:0] v;
        if (c >= CH_DIG0 && c <= CH_DIG9) begin
            v = c - CH_DIG0;
        end else if (c >= CH_LOW_A && c <= CH_LOW_F) begin
            v = c - CH_LOW_A + 8'd10;
        end else if (c >= CH_UP_A && c <= CH_UP_F) begin
            v = c - CH_UP_A + 8'd10;
        end else begin
            v = 8'd0;
        end
        return v[3:0];
    endfunction

    // Append one result to the group.
    function automatic void f_put(inout htk_pkg::t_bundle bd, input logic [7:0] b,
                                  input logic [2:0] kind, input logic data,
                                  input logic tend, input logic kept, input logic done,
                                  input logic [1:0] st);
        htk_pkg::t_result r;
        r.out_byte    = b;
        r.kind        = kind;
        r.is_data     = data;
        r.token_end   = tend;
        r.header_kept = kept;
        r.head_done   = done;
        r.status      = st;
        if (bd.count != 2'd3) begin
            bd.res[bd.count] = r;
            bd.count         = bd.count + 2'd1;
        end
    endfunction

    // A plain token byte in the current phase.
    function automatic void f_data(inout t_tok_state s, inout htk_pkg::t_bundle bd,
                                   input logic [7:0] b);
        unique case (s.phase)
            PH_TARGET: begin
                f_put(bd, b, htk_pkg::KIND_TARGET, 1'b1, 1'b0, 1'b0, 1'b0, htk_pkg::ST_OK);
            end
            PH_VERSION: begin
                f_put(bd, b, htk_pkg::KIND_VERSION, 1'b1, 1'b0, 1'b0, 1'b0, htk_pkg::ST_OK);
            end
            PH_NAME: begin
                s.name_seen = 1'b1;
                f_put(bd, b, htk_pkg::KIND_NAME, 1'b1, 1'b0, 1'b0, 1'b0, htk_pkg::ST_OK);
            end
            PH_VALUE: begin
                s.value_seen = 1'b1;
                f_put(bd, b, htk_pkg::KIND_VALUE, 1'b1, 1'b0, 1'b0, 1'b0, htk_pkg::ST_OK);
            end
            default: begin
                s.phase = PH_METHOD;
                f_put(bd, b, htk_pkg::KIND_METHOD, 1'b1, 1'b0, 1'b0, 1'b0, htk_pkg::ST_OK);
            end
        endcase
    endfunction

    function automatic void f_new_request(inout t_tok_state s);
        s.phase      = PH_LINE;
        s.name_seen  = 1'b0;
        s.value_seen = 1'b0;
    endfunction

    // A complete CR LF pair.
    function automatic void f_line_done(inout t_tok_state s, inout htk_pkg::t_bundle bd);
        unique case (s.phase)
            PH_METHOD: begin
                f_put(bd, 8'd0, htk_pkg::KIND_METHOD, 1'b0, 1'b1, 1'b0, 1'b1,
                      htk_pkg::ST_SHORT_LINE);
                f_new_request(s);
            end
            PH_TARGET: begin
                f_put(bd, 8'd0, htk_pkg::KIND_TARGET, 1'b0, 1'b1, 1'b0, 1'b1,
                      htk_pkg::ST_SHORT_LINE);
                f_new_request(s);
            end
            PH_VERSION: begin
                f_put(bd, 8'd0, htk_pkg::KIND_VERSION, 1'b0, 1'b1, 1'b0, 1'b0, htk_pkg::ST_OK);
                s.phase      = PH_NAME;
                s.name_seen  = 1'b0;
                s.value_seen = 1'b0;
            end
            PH_NAME: begin
                // A named line without a separator ends the head with an error.
                if (s.name_seen) begin
                    f_put(bd, 8'd0, htk_pkg::KIND_NAME, 1'b0, 1'b1, 1'b0, 1'b1,
                          htk_pkg::ST_NO_SEP);
                end else begin
                    f_put(bd, 8'd0, htk_pkg::KIND_METHOD, 1'b0, 1'b0, 1'b0, 1'b1,
                          htk_pkg::ST_OK);
                end
                f_new_request(s);
            end
            PH_VALUE: begin
                f_put(bd, 8'd0, htk_pkg::KIND_VALUE, 1'b0, 1'b1, s.name_seen && s.value_seen,
                      1'b0, htk_pkg::ST_OK);
                s.phase      = PH_NAME;
                s.name_seen  = 1'b0;
                s.value_seen = 1'b0;
            end
            default: begin
                s.phase = PH_LINE;
            end
        endcase
    endfunction

    // A byte with no CR pending.
    function automatic void f_take(inout t_tok_state s, inout htk_pkg::t_bundle bd,
                                   input logic [7:0] b);
        logic finished;
        finished = 1'b0;
        unique case (s.phase)
            PH_TARGET: begin
                // Resolve a held percent escape first.
                if (s.held_count == 2'd1) begin
                    if (f_is_hex(b)) begin
                        s.held_digit = b;
                        s.held_count = 2'd2;
                        finished     = 1'b1;
                    end else begin
                        s.held_count = 2'd0;
                        f_data(s, bd, CH_PERCENT);
                    end
                end else if (s.held_count >= 2'd2) begin
                    s.held_count = 2'd0;
                    if (f_is_hex(b)) begin
                        f_put(bd, {f_hex_val(s.held_digit), f_hex_val(b)}, htk_pkg::KIND_TARGET,
                              1'b1, 1'b0, 1'b0, 1'b0, htk_pkg::ST_OK);
                        finished = 1'b1;
                    end else begin
                        f_data(s, bd, CH_PERCENT);
                        f_data(s, bd, s.held_digit);
                    end
                end
                if (!finished) begin
                    if (b == CH_SPACE) begin
                        f_put(bd, 8'd0, htk_pkg::KIND_TARGET, 1'b0, 1'b1, 1'b0, 1'b0,
                              htk_pkg::ST_OK);
                        s.phase = PH_VERSION;
                    end else if (b == CH_PERCENT) begin
                        s.held_count = 2'd1;
                    end else if (b == CH_CR) begin
                        s.cr_held = 1'b1;
                    end else begin
                        f_data(s, bd, b);
                    end
                end
            end
            PH_VERSION, PH_VALUE: begin
                if (b == CH_CR) begin
                    s.cr_held = 1'b1;
                end else begin
                    f_data(s, bd, b);
                end
            end
            PH_NAME: begin
                // A held colon becomes the separator only when a space follows.
                if (s.colon_held) begin
                    s.colon_held = 1'b0;
                    if (b == CH_SPACE) begin
                        f_put(bd, 8'd0, htk_pkg::KIND_NAME, 1'b0, 1'b1, 1'b0, 1'b0,
                              htk_pkg::ST_OK);
                        s.phase  = PH_VALUE;
                        finished = 1'b1;
                    end else begin
                        f_data(s, bd, CH_COLON);
                    end
                end
                if (!finished) begin
                    if (b == CH_COLON) begin
                        s.colon_held = 1'b1;
                    end else if (b == CH_CR) begin
                        s.cr_held = 1'b1;
                    end else begin
                        f_data(s, bd, b);
                    end
                end
            end
            default: begin
                if (b == CH_SPACE) begin
                    f_put(bd, 8'd0, htk_pkg::KIND_METHOD, 1'b0, 1'b1, 1'b0, 1'b0,
                          htk_pkg::ST_OK);
                    s.phase = PH_TARGET;
                end else if (b == CH_CR) begin
                    s.cr_held = 1'b1;
                end else begin
                    f_data(s, bd, b);
                end
            end
        endcase
    endfunction

    // Next state and result group for the byte on the input.
    always_comb begin
        step_state  = r_state;
        step_bundle = '0;
        if (step_state.cr_held) begin
            step_state.cr_held = 1'b0;
            if (i_in.in_byte == CH_LF) begin
                f_line_done(step_state, step_bundle);
            end else begin
                f_data(step_state, step_bundle, CH_CR);
                f_take(step_state, step_bundle, i_in.in_byte);
            end
        end else begin
            f_take(step_state, step_bundle, i_in.in_byte);
        end
    end

    // Handshake: take a beat whenever the queue has room.
    assign i_in.ready = !i_full;
    assign accept     = i_in.valid && !i_full;
    assign o_push     = accept && (step_bundle.count != 2'd0);
    assign o_bundle   = step_bundle;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (accept) begin
            r_state <= step_state;
        end
    end

endmodule

// File: rtl/htk_queue.sv
`timescale 1ns / 1ps
// Queue of result groups between the front end and the back end.
module htk_queue #(
    parameter int DEPTH = htk_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  htk_pkg::t_bundle i_bundle,
    output logic             o_full,
    input  logic             i_pop,
    output htk_pkg::t_bundle o_bundle,
    output logic             o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    htk_pkg::t_bundle r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full   = (r_count == CNT_W'(DEPTH));
    assign o_empty  = (r_count == '0);
    assign o_bundle = r_mem[r_rd_ptr];
    assign do_push  = i_push && !o_full;
    assign do_pop   = i_pop && !o_empty;

    // Storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_bundle;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// File: rtl/htk_back.sv
`timescale 1ns / 1ps
// Back end: sends the results of the queued group one beat at a time.
module htk_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  htk_pkg::t_bundle i_bundle,
    input  logic             i_empty,
    output logic             o_pop,
    htk_res_if.source        o_out
);

    logic [1:0]       r_idx;
    htk_pkg::t_result cur;
    logic             is_last;
    logic             accept;

    assign cur     = i_bundle.res[r_idx];
    assign is_last = (r_idx == i_bundle.count - 2'd1);
    assign accept  = !i_empty && o_out.ready;
    assign o_pop   = accept && is_last;

    // Result beat fields.
    assign o_out.valid       = !i_empty;
    assign o_out.out_byte    = cur.out_byte;
    assign o_out.kind        = cur.kind;
    assign o_out.is_data     = cur.is_data;
    assign o_out.token_end   = cur.token_end;
    assign o_out.header_kept = cur.header_kept;
    assign o_out.head_done   = cur.head_done;
    assign o_out.status      = cur.status;
    assign o_out.last        = is_last;

    // Step through the group; restart at the first result once it is drained.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= 2'd0;
        end else if (accept) begin
            r_idx <= is_last ? 2'd0 : r_idx + 2'd1;
        end
    end

endmodule

// File: rtl/htk_checker.sv
`timescale 1ns / 1ps
// Port-level checks of the tokenizer, bound to its top level.
module htk_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_byte,
    input logic [2:0] i_kind,
    input logic       i_is_data,
    input logic       i_token_end,
    input logic       i_header_kept,
    input logic       i_head_done,
    input logic [1:0] i_status
);

    // Nothing is offered right after reset.
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("result offered after reset");

    // A stalled result beat stays offered.
    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result beat dropped while stalled");

    // Markers carry a zero byte.
    a_marker_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_is_data |-> i_out_byte == 8'd0)
        else $error("marker with nonzero byte");

    // An error status only appears on the beat that finishes the head.
    a_status_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status != htk_pkg::ST_OK |-> i_head_done && !i_is_data)
        else $error("error status outside head end");

    // A kept header is reported only on a header value end marker.
    a_kept_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_header_kept |->
            i_kind == htk_pkg::KIND_VALUE && i_token_end && !i_is_data)
        else $error("header kept flag on wrong beat");

endmodule

bind http_request_head_tokenizer_top htk_checker u_htk_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_out_byte    (o_out.out_byte),
    .i_kind        (o_out.kind),
    .i_is_data     (o_out.is_data),
    .i_token_end   (o_out.token_end),
    .i_header_kept (o_out.header_kept),
    .i_head_done   (o_out.head_done),
    .i_status      (o_out.status)
);
